// ----- rtl/text_console_cursor_engine_core_macros.svh -----
// Assertion macros for the text console cursor engine.
// Used by text_console_cursor_engine_core; expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TCCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TCCE_ASSERT_IMPL(lbl, ante, cons, msg)
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/tcce_pkg.sv -----
// Shared types and constants for the text console cursor engine.
// No dependencies; imported by text_console_cursor_engine_core.
package tcce_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_NUL   = 8'd0;

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_PLACE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_CURSOR = 2'd0,
    KIND_CELL   = 2'd1,
    KIND_ROW    = 2'd2,
    KIND_SCREEN = 2'd3
  } kind_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] char_code;
    logic [7:0] attr;
    logic [5:0] want_row;
    logic [6:0] want_col;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] phys_row;
    logic [6:0] cell_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [5:0] cur_row;
    logic [7:0] cur_col;
    logic [5:0] top_row;
    logic       last;
  } out_item_t;

endpackage

// ----- rtl/text_console_cursor_engine_core.sv -----
// Cursor and scroll engine of a character-cell text console.
// Depends on tcce_pkg and text_console_cursor_engine_core_macros.svh.

// At most one command is taken per clock. Cursor, top row and the results of a command are
// computed in the accepting cycle and land in a two-entry result buffer; a command
// gives one result, except a character written while the cursor is pending at the
// end of the screen, which gives a row clear (scroll) followed by the cell write as
// two results, in that order. A new command is taken whenever the buffer
// is empty or its last result transfers in that same cycle, so with an unstalled
// output the sustained rate is one command per cycle, but not across scrolling writes.
// Logical row r lives in physical row (top_row + r) mod ROWS; scrolling recycles the
// old top row by clearing it with the default attribute.
`include "text_console_cursor_engine_core_macros.svh"

module text_console_cursor_engine_core
  import tcce_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam logic [5:0] LAST_ROW = 6'(ROWS - 1);
  localparam logic [6:0] LAST_COL = 7'(COLS - 1);
  localparam logic [7:0] COLS_W   = 8'(COLS);
  localparam logic [6:0] ROWS_W   = 7'(ROWS);

  logic [5:0] row_r, row_nxt;
  logic [7:0] col_r, col_nxt;
  logic [5:0] top_r, top_nxt;
  logic [7:0] dflt_attr_r;
  logic [1:0] cnt_r;
  out_item_t  q0_r, q1_r;

  out_item_t  res0, res1, wres;
  logic       two_res;
  logic [5:0] row_a, top_a, top_inc;
  logic [7:0] col_a, col_inc;
  logic       in_acc, out_take;

  function automatic logic [5:0] phys_of(input logic [5:0] top, input logic [5:0] r);
    logic [6:0] sum;
    sum = {1'b0, top} + {1'b0, r};
    if (sum >= ROWS_W) begin
      sum = sum - ROWS_W;
    end
    return sum[5:0];
  endfunction

  assign out_take = out_valid && !out_stall;
  assign in_stall = !((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_take));
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q0_r;

  assign top_inc = (top_r == LAST_ROW) ? 6'd0 : 6'(top_r + 6'd1);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    top_nxt = top_r;
    two_res = 1'b0;
    res0    = '0;
    res1    = '0;
    wres    = '0;
    row_a   = row_r;
    col_a   = col_r;
    top_a   = top_r;
    col_inc = 8'd0;
    case (in_data.func)
      FUNC_CLEAR: begin
        row_nxt        = 6'd0;
        col_nxt        = 8'd0;
        res0.kind      = KIND_SCREEN;
        res0.cell_attr = dflt_attr_r;
      end
      FUNC_PLACE: begin
        row_nxt = (in_data.want_row > LAST_ROW) ? LAST_ROW : in_data.want_row;
        col_nxt = (in_data.want_col > LAST_COL) ? {1'b0, LAST_COL} : {1'b0, in_data.want_col};
        res0.kind     = KIND_CURSOR;
        res0.phys_row = phys_of(top_r, row_nxt);
      end
      FUNC_PUT: begin
        if (in_data.char_code == CHAR_NL) begin
          if (row_r >= LAST_ROW) begin
            row_nxt        = LAST_ROW;
            col_nxt        = 8'd0;
            top_nxt        = top_inc;
            res0.kind      = KIND_ROW;
            res0.phys_row  = top_r;
            res0.cell_attr = dflt_attr_r;
          end else begin
            row_nxt       = 6'(row_r + 6'd1);
            col_nxt       = 8'd0;
            res0.kind     = KIND_CURSOR;
            res0.phys_row = phys_of(top_r, row_nxt);
          end
        end else if (in_data.char_code == CHAR_BS) begin
          // step back in reading order, sticking at cell 0
          if (col_r != 8'd0) begin
            col_nxt = 8'(col_r - 8'd1);
          end else if (row_r != 6'd0) begin
            row_nxt = 6'(row_r - 6'd1);
            col_nxt = {1'b0, LAST_COL};
          end
          res0.kind      = KIND_CELL;
          res0.phys_row  = phys_of(top_r, row_nxt);
          res0.cell_col  = col_nxt[6:0];
          res0.cell_char = CHAR_SPACE;
          res0.cell_attr = in_data.attr;
        end else begin
          if (col_r >= COLS_W) begin
            if (row_r >= LAST_ROW) begin
              // pending at end of screen: scroll first
              two_res        = 1'b1;
              top_a          = top_inc;
              row_a          = LAST_ROW;
              col_a          = 8'd0;
              res0.kind      = KIND_ROW;
              res0.phys_row  = top_r;
              res0.cell_char = CHAR_NUL;
              res0.cell_attr = dflt_attr_r;
              res0.cur_row   = LAST_ROW;
              res0.cur_col   = 8'd0;
              res0.top_row   = top_inc;
              res0.last      = 1'b0;
            end else begin
              row_a = 6'(row_r + 6'd1);
              col_a = 8'd0;
            end
          end
          wres.kind      = KIND_CELL;
          wres.phys_row  = phys_of(top_a, row_a);
          wres.cell_col  = col_a[6:0];
          wres.cell_char = in_data.char_code;
          wres.cell_attr = in_data.attr;
          col_inc = 8'(col_a + 8'd1);
          top_nxt = top_a;
          row_nxt = row_a;
          col_nxt = col_inc;
          if ((col_inc >= COLS_W) && (row_a < LAST_ROW)) begin
            row_nxt = 6'(row_a + 6'd1);
            col_nxt = 8'd0;
          end
          if (two_res) begin
            res1 = wres;
          end else begin
            res0 = wres;
          end
        end
      end
      default: begin
        res0.kind     = KIND_CURSOR;
        res0.phys_row = phys_of(top_r, row_r);
      end
    endcase
    res1.cur_row = row_nxt;
    res1.cur_col = col_nxt;
    res1.top_row = top_nxt;
    res1.last    = 1'b1;
    if (!two_res) begin
      res0.cur_row = row_nxt;
      res0.cur_col = col_nxt;
      res0.top_row = top_nxt;
      res0.last    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= 6'd0;
      col_r       <= 8'd0;
      top_r       <= 6'd0;
      dflt_attr_r <= DEFAULT_ATTR_RST;
      cnt_r       <= 2'd0;
    end else begin
      if (cfg_we) begin
        dflt_attr_r <= cfg_wdata;
      end
      if (in_acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
        top_r <= top_nxt;
        cnt_r <= two_res ? 2'd2 : 2'd1;
      end else if (out_take) begin
        cnt_r <= 2'(cnt_r - 2'd1);
      end
    end
  end

  // result buffer payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q0_r <= res0;
      q1_r <= res1;
    end else if (out_take && (cnt_r == 2'd2)) begin
      q0_r <= q1_r;
    end
  end

  `TCCE_ASSERT_NEXT(a_accept_gives_result, in_valid && !in_stall, out_valid, "accepted command produced no result")
  `TCCE_ASSERT_IMPL(a_first_of_two, out_valid && !out_data.last, cnt_r == 2'd2, "non-final result without a second one queued")
  `TCCE_ASSERT_IMPL(a_pending_last_row, col_r == COLS_W, row_r == LAST_ROW, "cursor pending off the last row")
  `TCCE_ASSERT_IMPL(a_top_in_range, rst_n, {1'b0, top_r} < ROWS_W, "top row out of range")

endmodule
